[rtl/assert_macros.svh]
// assertion helpers included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset disables the check
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, reset disables the check
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/fptm_pkg.sv]
package fptm_pkg;

    // command opcodes
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_READ_C  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEPTH_K   = 2'd0;
    localparam logic [1:0] CFG_ROWS_USED = 2'd1;
    localparam logic [1:0] CFG_COLS_USED = 2'd2;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] elem_index;
        logic [2:0]  row_sel;
        logic [3:0]  col_sel;
        logic [31:0] operand_bits;
    } cmd_t;

    typedef struct packed {
        logic [31:0] sum_bits;
        logic        status;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_NORM,
        ST_ROUND,
        ST_ALIGN
    } state_t;

    // significand with hidden bit, zero for subnormals
    function automatic logic [23:0] fp_mant(input logic [31:0] x);
        return {|x[30:23], x[22:0]};
    endfunction

    // exponent with subnormals mapped to one
    function automatic logic [7:0] fp_exp(input logic [31:0] x);
        return (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    endfunction

    function automatic logic fp_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic fp_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [31:0] fp_canon(input logic [31:0] x);
        return fp_is_nan(x) ? CANON_NAN : x;
    endfunction

endpackage

[rtl/fp32_packed_tile_matmul_unit.sv]
// channel   | signals                          | handshake
// ----------+----------------------------------+-------------------------------
// command   | start, busy, cmd                 | taken when start & !busy
// result    | result_valid, result             | one-cycle strobe, no stall
// config    | cfg_valid, cfg_ready, cfg_index, | taken when cfg_valid &
//           | cfg_data                         | cfg_ready
//
// writes of A or B leave busy low
// each k step of a read runs memory read, multiply, normalize and round of the
// product, align, normalize and round of the sum, special values skipping the
// normalize and round; busy drops in the same cycle the result strobe rises
// errors and depth zero reads answer in the cycle after the transaction
// rst_n is asynchronous; the operand stores hold no reset and need no sweep
// results cannot be stalled by the receiver
`include "assert_macros.svh"

module fp32_packed_tile_matmul_unit #(
    parameter int TILE_ROWS = 6,
    parameter int TILE_COLS = 16,
    parameter int DEPTH_MAX = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fptm_pkg::cmd_t       cmd,
    output logic                 busy,
    output logic                 result_valid,
    output fptm_pkg::result_t    result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [8:0]           cfg_data
);

    localparam int A_DEPTH = DEPTH_MAX * TILE_ROWS;
    localparam int B_DEPTH = DEPTH_MAX * TILE_COLS;
    localparam int AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int BW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int KW = $clog2(DEPTH_MAX + 1);

    fptm_pkg::state_t state_reg, state_next;

    logic [8:0]  depth_k_reg;
    logic [2:0]  rows_used_reg;
    logic [4:0]  cols_used_reg;

    logic [AW-1:0] a_addr_reg, a_addr_next;
    logic [BW-1:0] b_addr_reg, b_addr_next;
    logic [KW-1:0] k_reg, k_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   prod_reg, prod_next;
    logic          phase_reg, phase_next;
    logic [50:0]   nrm_mant_reg, nrm_mant_next;
    logic signed [10:0] nrm_q_reg, nrm_q_next;
    logic          nrm_sign_reg, nrm_sign_next;
    logic [5:0]    lead_reg, lead_next;
    logic          result_valid_reg, result_valid_next;
    fptm_pkg::result_t result_reg, result_next;

    logic [31:0] a_mem [A_DEPTH];
    logic [31:0] b_mem [B_DEPTH];
    logic [31:0] a_rdata_reg;
    logic [31:0] b_rdata_reg;

    logic accept;
    logic a_ok, b_ok, row_ok, col_ok;
    logic [31:0] rlim, clim, deff;
    logic [KW-1:0] depth_eff;

    assign busy = state_reg != fptm_pkg::ST_IDLE;
    assign accept = start && !busy;
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // range checks
    always_comb
    begin
        rlim = (32'(rows_used_reg) > TILE_ROWS) ? 32'(TILE_ROWS) : 32'(rows_used_reg);
        clim = (32'(cols_used_reg) > TILE_COLS) ? 32'(TILE_COLS) : 32'(cols_used_reg);
        deff = (32'(depth_k_reg) > DEPTH_MAX) ? 32'(DEPTH_MAX) : 32'(depth_k_reg);
        depth_eff = KW'(deff);
        a_ok = 32'(cmd.elem_index) < 32'(A_DEPTH);
        b_ok = 32'(cmd.elem_index) < 32'(B_DEPTH);
        row_ok = 32'(cmd.row_sel) < rlim;
        col_ok = 32'(cmd.col_sel) < clim;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_k_reg <= 9'd1;
            rows_used_reg <= 3'd6;
            cols_used_reg <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fptm_pkg::CFG_DEPTH_K:   depth_k_reg <= cfg_data;
                fptm_pkg::CFG_ROWS_USED: rows_used_reg <= cfg_data[2:0];
                fptm_pkg::CFG_COLS_USED: cols_used_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // operand stores
    always_ff @(posedge clk)
    begin
        if (accept && cmd.op == fptm_pkg::OP_WRITE_A && a_ok)
        begin
            a_mem[AW'(cmd.elem_index)] <= cmd.operand_bits;
        end
        a_rdata_reg <= a_mem[a_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.op == fptm_pkg::OP_WRITE_B && b_ok)
        begin
            b_mem[BW'(cmd.elem_index)] <= cmd.operand_bits;
        end
        b_rdata_reg <= b_mem[b_addr_reg];
    end

    // product of the two operands read
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    logic        mul_sign, mul_special;
    logic [31:0] mul_special_bits;
    logic [47:0] mul_prod;
    logic signed [10:0] mul_q;

    always_comb
    begin
        ma = fptm_pkg::fp_mant(a_rdata_reg);
        mb = fptm_pkg::fp_mant(b_rdata_reg);
        ea = fptm_pkg::fp_exp(a_rdata_reg);
        eb = fptm_pkg::fp_exp(b_rdata_reg);
        mul_sign = a_rdata_reg[31] ^ b_rdata_reg[31];
        mul_prod = {24'd0, ma} * {24'd0, mb};
        mul_q = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd300;
        mul_special = 1'b1;
        mul_special_bits = {mul_sign, 31'd0};
        if (fptm_pkg::fp_is_nan(a_rdata_reg) || fptm_pkg::fp_is_nan(b_rdata_reg)
            || (fptm_pkg::fp_is_inf(a_rdata_reg) && fptm_pkg::fp_is_zero(b_rdata_reg))
            || (fptm_pkg::fp_is_zero(a_rdata_reg) && fptm_pkg::fp_is_inf(b_rdata_reg)))
        begin
            mul_special_bits = fptm_pkg::CANON_NAN;
        end
        else if (fptm_pkg::fp_is_inf(a_rdata_reg) || fptm_pkg::fp_is_inf(b_rdata_reg))
        begin
            mul_special_bits = {mul_sign, 8'hFF, 23'd0};
        end
        else if (fptm_pkg::fp_is_zero(a_rdata_reg) || fptm_pkg::fp_is_zero(b_rdata_reg))
        begin
            mul_special_bits = {mul_sign, 31'd0};
        end
        else
        begin
            mul_special = 1'b0;
        end
    end

    // alignment and add of accumulator and product
    logic        swap, big_s, sm_s, add_sign, add_special;
    logic [23:0] big_m, sm_m;
    logic [7:0]  big_e, sm_e, exp_diff;
    logic [5:0]  dshift;
    logic [49:0] big_w, sm_w;
    logic [113:0] sm_wide;
    logic [50:0] add_sum;
    logic signed [10:0] add_q;
    logic [31:0] add_special_bits;

    always_comb
    begin
        swap = fptm_pkg::fp_exp(prod_reg) > fptm_pkg::fp_exp(acc_reg);
        big_m = swap ? fptm_pkg::fp_mant(prod_reg) : fptm_pkg::fp_mant(acc_reg);
        big_e = swap ? fptm_pkg::fp_exp(prod_reg) : fptm_pkg::fp_exp(acc_reg);
        big_s = swap ? prod_reg[31] : acc_reg[31];
        sm_m = swap ? fptm_pkg::fp_mant(acc_reg) : fptm_pkg::fp_mant(prod_reg);
        sm_e = swap ? fptm_pkg::fp_exp(acc_reg) : fptm_pkg::fp_exp(prod_reg);
        sm_s = swap ? acc_reg[31] : prod_reg[31];
        exp_diff = big_e - sm_e;
        dshift = (exp_diff > 8'd63) ? 6'd63 : exp_diff[5:0];
        big_w = {big_m, 26'd0};
        sm_wide = {sm_m, 26'd0, 64'd0} >> dshift;
        sm_w = sm_wide[113:64] | {49'd0, |sm_wide[63:0]};
        if (big_s == sm_s)
        begin
            add_sum = {1'b0, big_w} + {1'b0, sm_w};
            add_sign = big_s;
        end
        else if (big_w >= sm_w)
        begin
            add_sum = {1'b0, big_w - sm_w};
            add_sign = big_s;
        end
        else
        begin
            add_sum = {1'b0, sm_w - big_w};
            add_sign = sm_s;
        end
        add_q = $signed({3'b000, big_e}) - 11'sd176;

        add_special = 1'b1;
        add_special_bits = 32'd0;
        if (fptm_pkg::fp_is_nan(acc_reg) || fptm_pkg::fp_is_nan(prod_reg)
            || (fptm_pkg::fp_is_inf(acc_reg) && fptm_pkg::fp_is_inf(prod_reg)
                && acc_reg[31] != prod_reg[31]))
        begin
            add_special_bits = fptm_pkg::CANON_NAN;
        end
        else if (fptm_pkg::fp_is_inf(acc_reg))
        begin
            add_special_bits = acc_reg;
        end
        else if (fptm_pkg::fp_is_inf(prod_reg))
        begin
            add_special_bits = prod_reg;
        end
        else if (fptm_pkg::fp_is_zero(acc_reg) && fptm_pkg::fp_is_zero(prod_reg))
        begin
            add_special_bits = {acc_reg[31] & prod_reg[31], 31'd0};
        end
        else if (fptm_pkg::fp_is_zero(acc_reg))
        begin
            add_special_bits = prod_reg;
        end
        else if (fptm_pkg::fp_is_zero(prod_reg))
        begin
            add_special_bits = acc_reg;
        end
        else if (add_sum == 51'd0)
        begin
            add_special_bits = 32'd0;
        end
        else
        begin
            add_special = 1'b0;
        end
    end

    // leading one search
    logic [5:0] lead_c;

    always_comb
    begin
        lead_c = 6'd0;
        for (int i = 0; i < 51; i++)
        begin
            if (nrm_mant_reg[i])
            begin
                lead_c = 6'(i);
            end
        end
    end

    // shift and round to nearest even
    logic signed [12:0] t1, tgt, shamt, tfin, biased;
    logic [5:0]   rshift;
    logic [114:0] rwide;
    logic [50:0]  lwide;
    logic [23:0]  keep, mfin;
    logic         guard, sticky, inc;
    logic [24:0]  m25;
    logic [31:0]  rnd_bits;

    always_comb
    begin
        t1 = 13'(nrm_q_reg) + $signed({7'd0, lead_reg}) - 13'sd23;
        tgt = (t1 < -13'sd149) ? -13'sd149 : t1;
        shamt = tgt - 13'(nrm_q_reg);
        rshift = (shamt > 13'sd63) ? 6'd63 : shamt[5:0];
        rwide = {nrm_mant_reg, 64'd0} >> rshift;
        lwide = nrm_mant_reg << 5'(-shamt);
        if (shamt >= 13'sd0)
        begin
            keep = rwide[87:64];
            guard = rwide[63];
            sticky = |rwide[62:0];
        end
        else
        begin
            keep = lwide[23:0];
            guard = 1'b0;
            sticky = 1'b0;
        end
        inc = guard && (sticky || keep[0]);
        m25 = {1'b0, keep} + {24'd0, inc};
        if (m25[24])
        begin
            mfin = m25[24:1];
            tfin = tgt + 13'sd1;
        end
        else
        begin
            mfin = m25[23:0];
            tfin = tgt;
        end
        biased = tfin + 13'sd150;
        if (!mfin[23])
        begin
            rnd_bits = {nrm_sign_reg, 8'd0, mfin[22:0]};
        end
        else if (biased >= 13'sd255)
        begin
            rnd_bits = {nrm_sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            rnd_bits = {nrm_sign_reg, biased[7:0], mfin[22:0]};
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fptm_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        k_reg <= k_next;
        acc_reg <= acc_next;
        prod_reg <= prod_next;
        phase_reg <= phase_next;
        nrm_mant_reg <= nrm_mant_next;
        nrm_q_reg <= nrm_q_next;
        nrm_sign_reg <= nrm_sign_next;
        lead_reg <= lead_next;
        result_reg <= result_next;
    end

    // next state and datapath control
    always_comb
    begin
        logic        step_done;
        logic [31:0] acc_new;
        state_next = state_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        k_next = k_reg;
        acc_next = acc_reg;
        prod_next = prod_reg;
        phase_next = phase_reg;
        nrm_mant_next = nrm_mant_reg;
        nrm_q_next = nrm_q_reg;
        nrm_sign_next = nrm_sign_reg;
        lead_next = lead_reg;
        result_valid_next = 1'b0;
        result_next = result_reg;
        step_done = 1'b0;
        acc_new = acc_reg;

        unique case (state_reg)
            fptm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        fptm_pkg::OP_WRITE_A:
                        begin
                            if (!a_ok)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{sum_bits: 32'd0, status: 1'b1};
                            end
                        end
                        fptm_pkg::OP_WRITE_B:
                        begin
                            if (!b_ok)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{sum_bits: 32'd0, status: 1'b1};
                            end
                        end
                        fptm_pkg::OP_READ_C:
                        begin
                            if (!row_ok || !col_ok)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{sum_bits: 32'd0, status: 1'b1};
                            end
                            else if (depth_eff == '0)
                            begin
                                result_valid_next = 1'b1;
                                result_next = '{sum_bits: 32'd0, status: 1'b0};
                            end
                            else
                            begin
                                a_addr_next = AW'(cmd.row_sel);
                                b_addr_next = BW'(cmd.col_sel);
                                k_next = '0;
                                acc_next = 32'd0;
                                state_next = fptm_pkg::ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            fptm_pkg::ST_READ:
            begin
                state_next = fptm_pkg::ST_MUL;
            end
            fptm_pkg::ST_MUL:
            begin
                if (mul_special)
                begin
                    prod_next = mul_special_bits;
                    state_next = fptm_pkg::ST_ALIGN;
                end
                else
                begin
                    nrm_mant_next = {3'd0, mul_prod};
                    nrm_q_next = mul_q;
                    nrm_sign_next = mul_sign;
                    phase_next = 1'b0;
                    state_next = fptm_pkg::ST_NORM;
                end
            end
            fptm_pkg::ST_NORM:
            begin
                lead_next = lead_c;
                state_next = fptm_pkg::ST_ROUND;
            end
            fptm_pkg::ST_ROUND:
            begin
                if (!phase_reg)
                begin
                    prod_next = rnd_bits;
                    state_next = fptm_pkg::ST_ALIGN;
                end
                else
                begin
                    acc_new = rnd_bits;
                    step_done = 1'b1;
                end
            end
            fptm_pkg::ST_ALIGN:
            begin
                if (add_special)
                begin
                    acc_new = add_special_bits;
                    step_done = 1'b1;
                end
                else
                begin
                    nrm_mant_next = add_sum;
                    nrm_q_next = add_q;
                    nrm_sign_next = add_sign;
                    phase_next = 1'b1;
                    state_next = fptm_pkg::ST_NORM;
                end
            end
            default:
            begin
                state_next = fptm_pkg::ST_IDLE;
            end
        endcase

        // end of one k step
        if (step_done)
        begin
            acc_next = acc_new;
            if (k_reg + KW'(1) == depth_eff)
            begin
                result_valid_next = 1'b1;
                result_next = '{sum_bits: fptm_pkg::fp_canon(acc_new), status: 1'b0};
                state_next = fptm_pkg::ST_IDLE;
            end
            else
            begin
                k_next = k_reg + KW'(1);
                a_addr_next = a_addr_reg + AW'(TILE_ROWS);
                b_addr_next = b_addr_reg + BW'(TILE_COLS);
                state_next = fptm_pkg::ST_READ;
            end
        end
    end

    // checks
    `ASSERT_IMPLIES(err_sum_zero, clk, rst_n, result_valid && result.status,
        result.sum_bits == 32'd0)
    `ASSERT_IMPLIES(nan_canonical, clk, rst_n, result_valid && !result.status,
        !(result.sum_bits[30:23] == 8'hFF && result.sum_bits[22:0] != 23'd0
          && result.sum_bits != fptm_pkg::CANON_NAN))
    `ASSERT_NEXT(read_answers, clk, rst_n, start && !busy && cmd.op == fptm_pkg::OP_READ_C,
        busy || result_valid)

endmodule
